// ----- src/tdp_pkg.sv -----
// tdp_pkg: constants, types and helper functions for the 2-D parity
// correct-and-repack block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

    localparam int WORD_BITS     = 64;
    localparam int DATA_BITS     = 49;
    localparam int SIDE          = 7;
    localparam int PAR_BITS      = 15;
    localparam int CHUNK_BITS    = 56;
    localparam int COUNT_W       = 6;
    localparam int COUNTER_WIDTH = 32;
    localparam int TOTAL_W       = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    // classified transaction handed from the front to the back
    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic                 det;
        logic                 cor;
    } tdp_class_t;

    function automatic logic one_hot7(input logic [SIDE-1:0] v);
        return (v != '0) && ((v & (v - 1'b1)) == '0);
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(
        input logic [COUNTER_WIDTH-1:0] v
    );
        return (&v) ? v : v + 1'b1;
    endfunction

    // low TOTAL_W bits of a counter, zero extended when the counter is narrower
    function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNTER_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/tdp_if.sv -----
// tdp_if: valid/ready channel interfaces for codewords and results.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdp_in_if
    import tdp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

interface tdp_out_if
    import tdp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CHUNK_BITS-1:0] chunk;
    logic                  chunk_valid;
    logic                  error_detected;
    logic                  error_corrected;
    logic [TOTAL_W-1:0]    detected_total;
    logic [TOTAL_W-1:0]    corrected_total;
    logic [TOTAL_W-1:0]    block_total;

    modport source (output valid, output chunk, output chunk_valid,
                    output error_detected, output error_corrected,
                    output detected_total, output corrected_total,
                    output block_total, input ready);
    modport sink   (input valid, input chunk, input chunk_valid,
                    input error_detected, input error_corrected,
                    input detected_total, input corrected_total,
                    input block_total, output ready);
endinterface

`default_nettype wire

// ----- src/tdp_front.sv -----
// tdp_front: syndrome computation and single-bit correction of a codeword.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_front
    import tdp_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] codeword,
    output tdp_class_t                entry
);

    logic [DATA_BITS-1:0] data;
    logic [SIDE-1:0]      row_par;
    logic [SIDE-1:0]      col_par;
    logic [SIDE-1:0]      syn_row;
    logic [SIDE-1:0]      syn_col;
    logic                 syn_all;
    logic                 cor;
    logic [DATA_BITS-1:0] flip;

    always_comb
    begin
        data = codeword[DATA_BITS-1:0];
        for (int r = 0; r < SIDE; r++)
        begin
            row_par[r] = ^data[r*SIDE +: SIDE];
        end
        for (int c = 0; c < SIDE; c++)
        begin
            col_par[c] = 1'b0;
            for (int r = 0; r < SIDE; r++)
            begin
                col_par[c] = col_par[c] ^ data[r*SIDE + c];
            end
        end
        syn_row = row_par ^ codeword[DATA_BITS +: SIDE];
        syn_col = col_par ^ codeword[DATA_BITS + SIDE +: SIDE];
        syn_all = (^data) ^ codeword[WORD_BITS-1];
        cor     = one_hot7(syn_row) && one_hot7(syn_col);
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                flip[r*SIDE + c] = cor & syn_row[r] & syn_col[c];
            end
        end
        entry.data = data ^ flip;
        entry.det  = (|syn_row) | (|syn_col) | syn_all;
        entry.cor  = cor;
    end

endmodule

`default_nettype wire

// ----- src/tdp_queue.sv -----
// tdp_queue: short FIFO of classified transactions between front and back.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_queue
    import tdp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire tdp_class_t push_data,
    output logic            not_full,
    input  wire logic       pop,
    output logic            not_empty,
    output tdp_class_t      head
);

    tdp_class_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     fill_next;

    assign not_full  = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/tdp_back.sv -----
// tdp_back: repacks corrected data into 56-bit chunks, keeps the saturating
// counters and holds the result register. Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_back
    import tdp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire tdp_class_t q_head,
    output logic            q_pop,
    tdp_out_if.source       result_ch
);

    logic [DATA_BITS-1:0]     left_reg, left_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNTER_WIDTH-1:0] det_cnt_reg, det_cnt_next;
    logic [COUNTER_WIDTH-1:0] cor_cnt_reg, cor_cnt_next;
    logic [COUNTER_WIDTH-1:0] blk_cnt_reg, blk_cnt_next;
    logic                     out_valid_reg;
    logic [CHUNK_BITS-1:0]    chunk_reg, chunk_next;
    logic                     chunk_valid_reg, chunk_valid_next;
    logic                     det_reg, cor_reg;
    logic [COUNT_W-1:0]       shl;
    logic [COUNT_W-1:0]       shr;
    logic [CHUNK_BITS-1:0]    packed_chunk;
    logic [DATA_BITS-1:0]     keep_mask;

    assign q_pop = q_valid && (!out_valid_reg || result_ch.ready);

    always_comb
    begin
        // pending count is always a multiple of seven between 0 and 49
        shl          = COUNT_W'(CHUNK_BITS) - cnt_reg;
        shr          = cnt_reg - COUNT_W'(SIDE);
        packed_chunk = (CHUNK_BITS'(left_reg) << shl) | (CHUNK_BITS'(q_head.data) >> shr);
        keep_mask    = (DATA_BITS'(1) << shr) - DATA_BITS'(1);
        if (cnt_reg < COUNT_W'(SIDE))
        begin
            // too few pending bits: new data replaces them, no chunk
            left_next        = q_head.data;
            cnt_next         = cnt_reg + COUNT_W'(DATA_BITS);
            chunk_next       = '0;
            chunk_valid_next = 1'b0;
        end
        else
        begin
            left_next        = q_head.data & keep_mask;
            cnt_next         = shr;
            chunk_next       = packed_chunk;
            chunk_valid_next = 1'b1;
        end
        blk_cnt_next = sat_inc(blk_cnt_reg);
        det_cnt_next = q_head.det ? sat_inc(det_cnt_reg) : det_cnt_reg;
        cor_cnt_next = q_head.cor ? sat_inc(cor_cnt_reg) : cor_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            cnt_reg       <= '0;
            det_cnt_reg   <= '0;
            cor_cnt_reg   <= '0;
            blk_cnt_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= left_next;
                cnt_reg       <= cnt_next;
                det_cnt_reg   <= det_cnt_next;
                cor_cnt_reg   <= cor_cnt_next;
                blk_cnt_reg   <= blk_cnt_next;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            chunk_reg       <= chunk_next;
            chunk_valid_reg <= chunk_valid_next;
            det_reg         <= q_head.det;
            cor_reg         <= q_head.cor;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.chunk           = chunk_reg;
    assign result_ch.chunk_valid     = chunk_valid_reg;
    assign result_ch.error_detected  = det_reg;
    assign result_ch.error_corrected = cor_reg;
    assign result_ch.detected_total  = to_total(det_cnt_reg);
    assign result_ch.corrected_total = to_total(cor_cnt_reg);
    assign result_ch.block_total     = to_total(blk_cnt_reg);

endmodule

`default_nettype wire

// ----- src/two_d_parity_correct_and_repack.sv -----
// Path: an accepted codeword transaction is written into the queue, then popped
//   into the result register; output stalls can hold it in the queue.
// Throughput: one codeword per cycle while the result side stays ready; the
//   front's parity tree is combinational and the back repacks at each pop.
// Reset: asynchronous, active low; clears queue pointers, pending bits,
//   pending count, the three counters and the result valid.
`timescale 1ns / 1ps
`default_nettype none

// Top level: 7x7 two-dimensional parity check with single-error correction,
// followed by repacking of the 49 data bits into 56-bit chunks.
//
// front : recomputes the 15 parity bits, forms the syndrome, flips the data
//         bit at the crossing of a single row and single column mismatch.
// queue : a four-entry FIFO decouples classification from repacking so that
//         either side can stall without stalling the other until the queue fills or runs empty.
// back  : appends corrected data to the pending bits, emits a chunk when 56
//         bits are available, updates the saturating counters and holds the
//         result in an output register.
module two_d_parity_correct_and_repack
    import tdp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tdp_in_if.sink     word_ch,
    tdp_out_if.source  result_ch
);

    tdp_class_t front_entry;
    tdp_class_t q_head;
    logic       q_not_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       push;

    // input is taken whenever the queue has room
    assign word_ch.ready = q_not_full;
    assign push          = word_ch.valid && q_not_full;

    tdp_front u_front (
        .codeword (word_ch.codeword),
        .entry    (front_entry)
    );

    tdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back pops whenever the queue is not empty and the result register is empty or being drained
    tdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

// ----- src/tdp_checker.sv -----
// tdp_checker: port-level assertions for the top level, attached by bind.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_checker
    import tdp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [CHUNK_BITS-1:0] chunk,
    input wire logic                  chunk_valid,
    input wire logic                  error_detected,
    input wire logic                  error_corrected,
    input wire logic [TOTAL_W-1:0]    detected_total,
    input wire logic [TOTAL_W-1:0]    corrected_total,
    input wire logic [TOTAL_W-1:0]    block_total
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_hold_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(block_total) && $stable(chunk))
        else $error("result payload changed while stalled");

    a_cor_needs_det: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_corrected |-> error_detected)
        else $error("correction reported without detection");

    a_idle_chunk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chunk_valid |-> chunk == '0)
        else $error("nonzero chunk without chunk_valid");

    a_total_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> corrected_total <= detected_total && detected_total <= block_total
                      && block_total != '0)
        else $error("counter totals out of order");

endmodule

bind two_d_parity_correct_and_repack tdp_checker u_tdp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .chunk           (result_ch.chunk),
    .chunk_valid     (result_ch.chunk_valid),
    .error_detected  (result_ch.error_detected),
    .error_corrected (result_ch.error_corrected),
    .detected_total  (result_ch.detected_total),
    .corrected_total (result_ch.corrected_total),
    .block_total     (result_ch.block_total)
);

`default_nettype wire

// ----- tb/tb_two_d_parity_correct_and_repack.sv -----
// Self-checking testbench for two_d_parity_correct_and_repack: 7x7 parity
// correction and 56-bit repacking, checked against an in-bench predictor.
// Depends on tdp_pkg, tdp_if and the block under test.
`timescale 1ns / 1ps

module tb_two_d_parity_correct_and_repack;
    import tdp_pkg::*;

    // Run ceiling. The slowest correct run is roughly 500 transactions, so this
    // leaves a wide margin.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to wait after the last expected result before judging.
    localparam int SETTLE_TICKS = 8;
    localparam int BURST_MAX    = 12;

    // One result transaction, field for field.
    typedef struct packed {
        logic [CHUNK_BITS-1:0] chunk;
        logic                  chunk_valid;
        logic                  error_detected;
        logic                  error_corrected;
        logic [TOTAL_W-1:0]    detected_total;
        logic [TOTAL_W-1:0]    corrected_total;
        logic [TOTAL_W-1:0]    block_total;
    } repack_report_t;

    // Scoreboard: mirrors the syndrome decode, the bit repacker and the
    // saturating counters, and keeps the reports still owed by the block.
    class repack_scoreboard;
        repack_report_t           awaited_reports[$];
        logic [DATA_BITS-1:0]     carry_bits;
        int unsigned              carry_count;
        logic [COUNTER_WIDTH-1:0] detected_cnt;
        logic [COUNTER_WIDTH-1:0] corrected_cnt;
        logic [COUNTER_WIDTH-1:0] block_cnt;
        int                       errors;

        function new();
            carry_bits    = '0;
            carry_count   = 0;
            detected_cnt  = '0;
            corrected_cnt = '0;
            block_cnt     = '0;
            errors        = 0;
        endfunction

        // Parity bits in codeword order: rows 0..6, columns 7..13, overall 14.
        static function logic [PAR_BITS-1:0] grid_parity(input logic [DATA_BITS-1:0] d);
            logic [PAR_BITS-1:0] p;
            int r;
            int c;
            p = '0;
            for (r = 0; r < SIDE; r++)
            begin
                for (c = 0; c < SIDE; c++)
                begin
                    p[r]        ^= d[r*SIDE + c];
                    p[SIDE + c] ^= d[r*SIDE + c];
                end
            end
            p[2*SIDE] = ^d;
            return p;
        endfunction

        static function logic [COUNTER_WIDTH-1:0] bump(input logic [COUNTER_WIDTH-1:0] v);
            return (v == {COUNTER_WIDTH{1'b1}}) ? v : v + 1'b1;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // Accepted codeword: advance the mirrored state, queue its report.
        function void note_codeword(input logic [WORD_BITS-1:0] w);
            logic [DATA_BITS-1:0] data;
            logic [PAR_BITS-1:0]  syn;
            logic [63:0]          acc;
            int                   nr;
            int                   nc;
            int                   ir;
            int                   ic;
            int                   i;
            int unsigned          rest;
            repack_report_t       rep;

            data = w[DATA_BITS-1:0];
            syn  = grid_parity(data) ^ w[WORD_BITS-1:DATA_BITS];
            rep  = '0;
            block_cnt = bump(block_cnt);

            if (syn != '0)
            begin
                rep.error_detected = 1'b1;
                detected_cnt = bump(detected_cnt);
                nr = 0; nc = 0; ir = 0; ic = 0;
                for (i = 0; i < SIDE; i++)
                begin
                    if (syn[i])        begin nr++; ir = i; end
                    if (syn[SIDE + i]) begin nc++; ic = i; end
                end
                // overall bit plays no part in locating the flip
                if (nr == 1 && nc == 1)
                begin
                    data[ir*SIDE + ic] = ~data[ir*SIDE + ic];
                    rep.error_corrected = 1'b1;
                    corrected_cnt = bump(corrected_cnt);
                end
            end

            if (carry_count + DATA_BITS < CHUNK_BITS)
            begin
                // pending bits get shifted out past bit 48; count is zero here anyway
                carry_bits  = data;
                carry_count = carry_count + DATA_BITS;
            end
            else
            begin
                rest = carry_count + DATA_BITS - CHUNK_BITS;
                acc  = (64'(carry_bits) << (CHUNK_BITS - carry_count)) + (64'(data) >> rest);
                rep.chunk       = acc[CHUNK_BITS-1:0];
                rep.chunk_valid = 1'b1;
                acc  = 64'(data) & ((64'd1 << rest) - 64'd1);
                carry_bits  = acc[DATA_BITS-1:0];
                carry_count = rest;
            end

            rep.detected_total  = TOTAL_W'(detected_cnt);
            rep.corrected_total = TOTAL_W'(corrected_cnt);
            rep.block_total     = TOTAL_W'(block_cnt);
            awaited_reports.push_back(rep);
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input repack_report_t got);
            repack_report_t want;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited_reports.pop_front();
            compare_field("chunk",           64'(want.chunk),           64'(got.chunk));
            compare_field("chunk_valid",     64'(want.chunk_valid),     64'(got.chunk_valid));
            compare_field("error_detected",  64'(want.error_detected),  64'(got.error_detected));
            compare_field("error_corrected", 64'(want.error_corrected), 64'(got.error_corrected));
            compare_field("detected_total",  64'(want.detected_total),  64'(got.detected_total));
            compare_field("corrected_total", 64'(want.corrected_total), 64'(got.corrected_total));
            compare_field("block_total",     64'(want.block_total),     64'(got.block_total));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tdp_in_if  word_ch();
    tdp_out_if result_ch();

    two_d_parity_correct_and_repack uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .word_ch   (word_ch),
        .result_ch (result_ch)
    );

    repack_scoreboard sb = new();

    // Result-side stall shape, changed per phase by the main sequence.
    int             stall_pct;
    int             stall_max;
    int             stall_left;
    int unsigned    cycle_count;
    repack_report_t seen_report;
    logic [63:0]    word_batch[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // Known values on every block input from time zero.
    initial
    begin
        rst_n            = 1'b0;
        word_ch.valid    = 1'b0;
        word_ch.codeword = '0;
        result_ch.ready  = 1'b0;
        stall_pct        = 0;
        stall_max        = 0;
        stall_left       = 0;
        cycle_count      = 0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL two_d_parity_correct_and_repack");
            $finish;
        end
    end

    // Result sink: ready high unless a stall of random length is running.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, stall_max);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Transaction monitors. Both handshakes are sampled at the same edge the
    // block sees them; a result can never share an edge with its own input.
    always @(posedge clk)
    begin
        if (rst_n && word_ch.valid && word_ch.ready)
            sb.note_codeword(word_ch.codeword);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_report.chunk           = result_ch.chunk;
            seen_report.chunk_valid     = result_ch.chunk_valid;
            seen_report.error_detected  = result_ch.error_detected;
            seen_report.error_corrected = result_ch.error_corrected;
            seen_report.detected_total  = result_ch.detected_total;
            seen_report.corrected_total = result_ch.corrected_total;
            seen_report.block_total     = result_ch.block_total;
            sb.check_result(seen_report);
        end
    end

    function automatic logic [WORD_BITS-1:0] encode(input logic [DATA_BITS-1:0] d);
        return {repack_scoreboard::grid_parity(d), d};
    endfunction

    // Mostly well-formed codewords carrying zero, one or two flipped bits,
    // plus some raw noise.
    function automatic logic [WORD_BITS-1:0] random_codeword();
        logic [63:0] raw;
        logic [63:0] w;
        int          sel;
        int          a;
        int          b;
        raw = {$urandom(), $urandom()};
        w   = encode(raw[DATA_BITS-1:0]);
        sel = $urandom_range(0, 99);
        a   = $urandom_range(0, WORD_BITS-1);
        b   = $urandom_range(0, WORD_BITS-1);
        if (b == a)
            b = (a + 1) % WORD_BITS;
        if (sel < 45)
            w[a] = ~w[a];
        else if (sel < 60)
        begin
            w[a] = ~w[a];
            w[b] = ~w[b];
        end
        else if (sel < 70)
        begin
            // single data flip landing in the upper grid rows
            a = $urandom_range(32, DATA_BITS-1);
            w[a] = ~w[a];
        end
        else if (sel < 85)
            w = w;
        else
            w = {$urandom(), $urandom()};
        return w;
    endfunction

    // Holds valid until the block takes the transaction; returns at that edge.
    task automatic send_codeword(input logic [WORD_BITS-1:0] w);
        word_ch.valid    <= 1'b1;
        word_ch.codeword <= w;
        @(posedge clk);
        while (!word_ch.ready)
            @(posedge clk);
    endtask

    // Sends word_batch in bursts with random gaps. valid is left high at the
    // end so a following batch continues back to back.
    task automatic send_batch(input int gap_max);
        int burst_left;
        int gap;
        int i;
        burst_left = $urandom_range(1, BURST_MAX);
        for (i = 0; i < word_batch.size(); i++)
        begin
            send_codeword(word_batch[i]);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, BURST_MAX);
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap != 0 && i != word_batch.size() - 1)
                begin
                    word_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        word_batch.delete();
    endtask

    // Sender holds off until every outstanding report is back.
    task automatic drain_results();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int gap_max,
                                input int pct, input int smax);
        int i;
        stall_pct <= pct;
        stall_max <= smax;
        for (i = 0; i < count; i++)
            word_batch.push_back(random_codeword());
        send_batch(gap_max);
    endtask

    initial
    begin
        logic [WORD_BITS-1:0] w;
        logic [DATA_BITS-1:0] d;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, clean words, single data flips across the
        // grid (upper rows included), parity-bit-only errors, double flips,
        // a false correction from one row and one column parity flip.
        d = 49'h0_A5A5_3C3C_0F0F;
        word_batch.push_back(encode('0));
        word_batch.push_back({WORD_BITS{1'b1}});              // clean: all ones
        word_batch.push_back(64'h0);
        word_batch.push_back(encode(d));
        word_batch.push_back(encode(d) ^ (64'd1 << 0));       // top-left corner
        word_batch.push_back(encode(d) ^ (64'd1 << 6));
        word_batch.push_back(encode(d) ^ (64'd1 << 31));
        word_batch.push_back(encode(d) ^ (64'd1 << 32));
        word_batch.push_back(encode(d) ^ (64'd1 << 40));
        word_batch.push_back(encode(d) ^ (64'd1 << 42));
        word_batch.push_back(encode('1) ^ (64'd1 << 48));     // bottom-right corner
        word_batch.push_back(encode(d) ^ (64'd1 << 63));      // overall parity only
        word_batch.push_back(encode(d) ^ (64'd1 << 49));      // one row parity bit
        word_batch.push_back(encode(d) ^ (64'd1 << 62));      // one column parity bit
        word_batch.push_back(encode(d) ^ (64'd1 << 8) ^ (64'd1 << 10));   // same row
        word_batch.push_back(encode(d) ^ (64'd1 << 3) ^ (64'd1 << 24));   // same column
        word_batch.push_back(encode(d) ^ (64'd1 << 17) ^ (64'd1 << 63));  // data + overall
        word_batch.push_back(encode(d) ^ (64'd1 << 52) ^ (64'd1 << 59));  // false fix
        word_batch.push_back(encode('0) ^ (64'h7F << 49));                // all rows bad
        word_batch.push_back(64'h5555_5555_5555_5555);
        word_batch.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        w = {$urandom(), $urandom()};
        word_batch.push_back(w);
        word_batch.push_back(~w);
        stall_pct <= 25;
        stall_max <= 3;
        send_batch(2);

        // Pause until the directed set is fully checked.
        drain_results();

        // Random: full streaming, then mixed sender gaps and result-side stalls.
        random_phase(90, 0, 0, 0);
        random_phase(90, 3, 30, 4);
        drain_results();
        random_phase(90, 8, 0, 0);
        random_phase(90, 0, 50, 10);
        random_phase(90, 5, 20, 3);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS two_d_parity_correct_and_repack");
        else
            $display("FAIL two_d_parity_correct_and_repack");
        $finish;
    end

endmodule
